[sv/consistent_hash_backend_select_unit_macros.svh]
// Assertion macros for the consistent-hash backend selector.
// Used by consistent_hash_backend_select_unit.sv; needs a clk and rst_n in scope.
`ifndef CONSISTENT_HASH_BACKEND_SELECT_UNIT_MACROS_SVH
`define CONSISTENT_HASH_BACKEND_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chbs: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CHBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chbs: next-cycle check failed");

`endif

[sv/chbs_pkg.sv]
// Shared types, register codes and small arithmetic helpers for the
// consistent-hash backend selector. No dependencies.
package chbs_pkg;

  // Table dimensions: bucket rows and entries per row.
  localparam int MAX_BUCKETS  = 64;
  localparam int MAX_BACKENDS = 32;

  // Configuration register indexes.
  localparam logic REG_BUCKET_COUNT  = 1'b0;
  localparam logic REG_BACKEND_COUNT = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [6:0] BUCKET_COUNT_RST  = 7'd61;
  localparam logic [5:0] BACKEND_COUNT_RST = 6'd32;

  // Key reduction of a 32-bit key, eight key bits per cycle.
  localparam int KEY_W      = 32;
  localparam int KEY_CHUNK  = 8;
  localparam int MOD_CYCLES = KEY_W / KEY_CHUNK;

  // Offset multiplier of the backend walk.
  localparam logic [4:0] OFFSET_MULT = 5'd31;

  // Operation codes.
  localparam logic FUNC_REBUILD = 1'b0;
  localparam logic FUNC_LOOKUP  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] key_hash;
    logic [31:0] active_mask;
  } chbs_in_t;

  typedef struct packed {
    logic       found;
    logic [4:0] backend;
  } chbs_out_t;

  // Offset multiplier reduced modulo the table height, by restoring subtraction.
  function automatic logic [6:0] mult_mod(input logic [6:0] h);
    logic [11:0] x;
    logic [11:0] hs;
    x = 12'(OFFSET_MULT);
    for (int k = 4; k >= 0; k--) begin
      hs = 12'(h) << k;
      if (x >= hs) begin
        x = x - hs;
      end
    end
    return 7'(x);
  endfunction

  // Sum of two values modulo h, valid while the sum stays below 2*h.
  function automatic logic [6:0] add_mod(input logic [6:0] a, input logic [6:0] b,
                                         input logic [6:0] h);
    logic [7:0] s;
    s = 8'(a) + 8'(b);
    if (s >= 8'(h)) begin
      s = s - 8'(h);
    end
    return 7'(s);
  endfunction

endpackage

[sv/consistent_hash_backend_select_unit.sv]
// Top level of the consistent-hash backend selector: sequencer, table memories
// and result register. Depends on chbs_pkg and the assertion macro header.
//
// A lookup transaction runs from acceptance through these states, the handover
// waiting while the result register is full: S_MOD reduces the key modulo the
// table height (eight key bits per cycle), S_RDROW reads the bucket row and
// its fill count from the two memories, S_MATCH masks the row, S_ENC picks the
// first active entry and S_DONE hands the result over. A rebuild clears the
// fill counters of all MAX_BUCKETS rows, then reads and writes back the fill
// counter for each of height * backends placements, with setup before and
// handover after. After reset the block clears the fill-counter memory and
// accepts no transaction in that time; configuration writes are taken
// throughout. One transaction is in work at a time; a finished result waits
// in the output register while the next transaction is accepted.
`include "consistent_hash_backend_select_unit_macros.svh"

module consistent_hash_backend_select_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  chbs_pkg::chbs_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output chbs_pkg::chbs_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [chbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Table dimensions.
  localparam int MAX_BUCKETS  = chbs_pkg::MAX_BUCKETS;
  localparam int MAX_BACKENDS = chbs_pkg::MAX_BACKENDS;

  // Entry width, row address width and fill-counter width.
  localparam int EW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int RW = $clog2(MAX_BUCKETS);
  localparam int FW = $clog2(MAX_BACKENDS + 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_MOD   = 10'b00_0000_0100,
    S_RDROW = 10'b00_0000_1000,
    S_MATCH = 10'b00_0001_0000,
    S_ENC   = 10'b00_0010_0000,
    S_SETUP = 10'b00_0100_0000,
    S_FRD   = 10'b00_1000_0000,
    S_FWR   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  typedef logic [MAX_BACKENDS-1:0][EW-1:0] row_t;

  // Memories: bucket rows and per-row fill counters.
  row_t          tab_mem [MAX_BUCKETS];
  logic [FW-1:0] fc_mem  [MAX_BUCKETS];

  state_t              state_r, state_nxt;
  logic [RW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                rebuild_pend_r, rebuild_pend_nxt;
  logic [6:0]          bucket_count_r;
  logic [5:0]          backend_count_r;
  logic [31:0]         key_r, key_nxt;
  logic [31:0]         mask_r, mask_nxt;
  logic [6:0]          rem_r, rem_nxt;
  logic [1:0]          mod_cnt_r, mod_cnt_nxt;
  logic [MAX_BACKENDS-1:0] hit_r, hit_nxt;
  logic [6:0]          round_r, round_nxt;
  logic [EW-1:0]       b_r, b_nxt;
  logic [6:0]          m_r, m_nxt;
  logic [6:0]          row_r, row_nxt;
  logic [6:0]          d1_r, d1_nxt;
  logic [6:0]          d2_r, d2_nxt;
  logic                res_found_r, res_found_nxt;
  logic [4:0]          res_backend_r, res_backend_nxt;
  logic                out_valid_r, out_valid_nxt;
  chbs_pkg::chbs_out_t out_data_r, out_data_nxt;

  row_t                tab_rd_r;
  logic [FW-1:0]       fc_rd_r;

  logic                fc_we, fc_re, tab_we, tab_re;
  logic [RW-1:0]       fc_waddr, rd_addr;
  logic [FW-1:0]       fc_wdata;
  logic [EW-1:0]       tab_lane;

  logic [6:0]          h_eff;
  logic [5:0]          n_eff;
  logic [6:0]          mod_t;
  logic [7:0]          mod_u;
  logic [8:0]          used;
  logic [8:0]          cand_x;
  logic [EW-1:0]       sel;
  logic                wrap;
  logic                in_acc;

  // Effective table height and row width, saturated to the supported range.
  always_comb begin
    if (bucket_count_r < 7'd2) begin
      h_eff = 7'd2;
    end else if (32'(bucket_count_r) > 32'(MAX_BUCKETS)) begin
      h_eff = 7'(MAX_BUCKETS);
    end else begin
      h_eff = bucket_count_r;
    end
    if (backend_count_r == 6'd0) begin
      n_eff = 6'd1;
    end else if (32'(backend_count_r) > 32'(MAX_BACKENDS)) begin
      n_eff = 6'(MAX_BACKENDS);
    end else begin
      n_eff = backend_count_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r  <= chbs_pkg::BUCKET_COUNT_RST;
      backend_count_r <= chbs_pkg::BACKEND_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        chbs_pkg::REG_BUCKET_COUNT:  bucket_count_r  <= cfg_wdata[6:0];
        chbs_pkg::REG_BACKEND_COUNT: backend_count_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Eight restoring steps of the key reduction modulo the height.
  always_comb begin
    mod_t = rem_r;
    mod_u = 8'd0;
    for (int j = 0; j < chbs_pkg::KEY_CHUNK; j++) begin
      mod_u = {mod_t, key_r[chbs_pkg::KEY_W-1-j]};
      if (mod_u >= 8'(h_eff)) begin
        mod_u = mod_u - 8'(h_eff);
      end
      mod_t = 7'(mod_u);
    end
  end

  // Entries of the fetched row that hold an active backend.
  always_comb begin
    used = 9'(fc_rd_r);
    if (used > 9'(n_eff)) begin
      used = 9'(n_eff);
    end
    for (int i = 0; i < MAX_BACKENDS; i++) begin
      cand_x     = 9'(tab_rd_r[i]);
      hit_nxt[i] = (9'(i) < used) && (cand_x < 9'd32) && mask_r[5'(tab_rd_r[i])];
    end
  end

  // First active entry in priority order.
  always_comb begin
    sel = '0;
    for (int i = MAX_BACKENDS - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        sel = EW'(i);
      end
    end
  end

  // The step counter of the current backend wraps back to zero on the next backend.
  assign wrap = (m_r == (h_eff - 7'd2));

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    rebuild_pend_nxt = rebuild_pend_r;
    key_nxt          = key_r;
    mask_nxt         = mask_r;
    rem_nxt          = rem_r;
    mod_cnt_nxt      = mod_cnt_r;
    round_nxt        = round_r;
    b_nxt            = b_r;
    m_nxt            = m_r;
    row_nxt          = row_r;
    d1_nxt           = d1_r;
    d2_nxt           = d2_r;
    res_found_nxt    = res_found_r;
    res_backend_nxt  = res_backend_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    fc_we            = 1'b0;
    fc_waddr         = clr_cnt_r;
    fc_wdata         = '0;
    fc_re            = 1'b0;
    tab_we           = 1'b0;
    tab_re           = 1'b0;
    tab_lane         = EW'(fc_rd_r);
    rd_addr          = RW'(row_r);

    case (state_r)
      // Fill-counter clearing pass, after reset and at the start of a rebuild.
      S_CLEAR: begin
        fc_we       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + RW'(1);
        if (clr_cnt_r == RW'(MAX_BUCKETS - 1)) begin
          clr_cnt_nxt      = '0;
          rebuild_pend_nxt = 1'b0;
          state_nxt        = rebuild_pend_r ? S_SETUP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          key_nxt   = in_data.key_hash;
          mask_nxt  = in_data.active_mask;
          rem_nxt   = '0;
          mod_cnt_nxt = '0;
          if (in_data.func == chbs_pkg::FUNC_LOOKUP) begin
            state_nxt = S_MOD;
          end else begin
            rebuild_pend_nxt = 1'b1;
            state_nxt        = S_CLEAR;
          end
        end
      end
      S_MOD: begin
        rem_nxt     = mod_t;
        key_nxt     = key_r << chbs_pkg::KEY_CHUNK;
        mod_cnt_nxt = mod_cnt_r + 2'd1;
        if (mod_cnt_r == 2'(chbs_pkg::MOD_CYCLES - 1)) begin
          state_nxt = S_RDROW;
        end
      end
      S_RDROW: begin
        rd_addr   = RW'(rem_r);
        fc_re     = 1'b1;
        tab_re    = 1'b1;
        state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_ENC;
      end
      S_ENC: begin
        res_found_nxt   = |hit_r;
        res_backend_nxt = (|hit_r) ? 5'(tab_rd_r[sel]) : 5'd0;
        state_nxt       = S_DONE;
      end
      // Round zero: every walk starts from its offset; backend zero at row zero.
      S_SETUP: begin
        round_nxt = '0;
        b_nxt     = '0;
        m_nxt     = '0;
        row_nxt   = '0;
        d1_nxt    = chbs_pkg::mult_mod(h_eff);
        d2_nxt    = chbs_pkg::mult_mod(h_eff);
        state_nxt = S_FRD;
      end
      S_FRD: begin
        fc_re     = 1'b1;
        state_nxt = S_FWR;
      end
      // Append the backend to its row if there is room, then move on.
      S_FWR: begin
        fc_waddr = RW'(row_r);
        fc_wdata = fc_rd_r + FW'(1);
        if (9'(fc_rd_r) < 9'(n_eff)) begin
          fc_we  = 1'b1;
          tab_we = 1'b1;
        end
        state_nxt = S_FRD;
        if (9'(b_r) == 9'(n_eff) - 9'd1) begin
          if (round_r == h_eff - 7'd1) begin
            res_found_nxt   = 1'b0;
            res_backend_nxt = 5'd0;
            state_nxt       = S_DONE;
          end else begin
            round_nxt = round_r + 7'd1;
            row_nxt   = round_r + 7'd1;
            b_nxt     = '0;
            m_nxt     = '0;
            d1_nxt    = chbs_pkg::add_mod(d1_r, 7'd1, h_eff);
            d2_nxt    = chbs_pkg::add_mod(d2_r, 7'd2, h_eff);
          end
        end else begin
          b_nxt   = b_r + EW'(1);
          m_nxt   = wrap ? 7'd0 : (m_r + 7'd1);
          row_nxt = chbs_pkg::add_mod(row_r, wrap ? d2_r : d1_r, h_eff);
        end
      end
      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.found   = res_found_r;
          out_data_nxt.backend = res_backend_r;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      rebuild_pend_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      rebuild_pend_r <= rebuild_pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    mask_r        <= mask_nxt;
    rem_r         <= rem_nxt;
    mod_cnt_r     <= mod_cnt_nxt;
    hit_r         <= hit_nxt;
    round_r       <= round_nxt;
    b_r           <= b_nxt;
    m_r           <= m_nxt;
    row_r         <= row_nxt;
    d1_r          <= d1_nxt;
    d2_r          <= d2_nxt;
    res_found_r   <= res_found_nxt;
    res_backend_r <= res_backend_nxt;
    out_data_r    <= out_data_nxt;
  end

  // Fill-counter memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (fc_we) begin
      fc_mem[fc_waddr] <= fc_wdata;
    end
    if (fc_re) begin
      fc_rd_r <= fc_mem[rd_addr];
    end
  end

  // Bucket-row memory: one entry written, one whole row read.
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[RW'(row_r)][tab_lane] <= b_r;
    end
    if (tab_re) begin
      tab_rd_r <= tab_mem[rd_addr];
    end
  end

  // A rebuild never finds a row holding more entries than the row width.
  `CHBS_ASSERT_NOW(a_slot_bound, state_r == S_FWR, 9'(fc_rd_r) <= 9'(n_eff))
  // Walk positions and the key remainder stay inside the table.
  `CHBS_ASSERT_NOW(a_row_bound, state_r == S_FRD || state_r == S_FWR, row_r < h_eff)
  `CHBS_ASSERT_NOW(a_rem_bound, state_r == S_MOD || state_r == S_RDROW, rem_r < h_eff)
  // An accepted transaction leaves the idle state at once.
  `CHBS_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)
  // A result is only loaded from the handover state.
  `CHBS_ASSERT_NEXT(a_load_from_done, !out_valid_r && !(state_r == S_DONE), !out_valid_r)

endmodule
